// ===== hw/rtl/gosd_pkg.sv =====
// Package for the group order swap detector.
// Holds sizes, the cell broadcast struct and the swap compare function.
// No dependencies.
package gosd_pkg;

  localparam int MAX_GROUP   = 64;
  localparam int VALUE_WIDTH = 32;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    logic   load;
    logic   shift;
    logic   clear;
    logic   asc;
    value_t left;
    value_t right;
  } bcast_t;

  function automatic logic is_swap(input logic asc, input value_t la, input value_t ra,
                                   input value_t lb, input value_t rb);
    logic lt_l;
    logic gt_l;
    logic lt_r;
    logic gt_r;
    lt_l = la < lb;
    gt_l = la > lb;
    lt_r = ra < rb;
    gt_r = ra > rb;
    if (asc) begin
      return (lt_l && gt_r) || (gt_l && lt_r);
    end
    return (gt_l && gt_r) || (lt_l && lt_r);
  endfunction

endpackage

// ===== hw/rtl/gosd_cell.sv =====
// One storage cell of the group chain: holds one tuple of the open group.
// Compares the broadcast tuple with its own and shifts from its neighbor.
// Depends on gosd_pkg.
module gosd_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  gosd_pkg::bcast_t    bcast,
  input  gosd_pkg::value_t    prev_left,
  input  gosd_pkg::value_t    prev_right,
  input  logic                prev_valid,
  output gosd_pkg::value_t    cell_left,
  output gosd_pkg::value_t    cell_right,
  output logic                cell_valid,
  output logic                hit
);

  gosd_pkg::value_t left_r;
  gosd_pkg::value_t right_r;
  logic             valid_r;
  logic             valid_nxt;
  logic             hit_r;

  always_comb begin
    valid_nxt = valid_r;
    if (bcast.shift) begin
      valid_nxt = prev_valid;
    end
    if (bcast.clear) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (bcast.shift) begin
      left_r  <= prev_left;
      right_r <= prev_right;
    end
    if (bcast.load) begin
      hit_r <= valid_r &&
               gosd_pkg::is_swap(bcast.asc, left_r, right_r, bcast.left, bcast.right);
    end
  end

  assign cell_left  = left_r;
  assign cell_right = right_r;
  assign cell_valid = valid_r;
  assign hit        = hit_r;

endmodule

// ===== hw/rtl/gosd_cell_row.sv =====
// Row of MAX_GROUP cells chained left to right; new tuples enter cell 0.
// Reports the registered per-cell swap hits and whether the row is full.
// Depends on gosd_pkg and gosd_cell.
module gosd_cell_row (
  input  logic                               clk,
  input  logic                               rst_n,
  input  gosd_pkg::bcast_t                   bcast,
  output logic [gosd_pkg::MAX_GROUP-1:0]     hits,
  output logic                               full
);

  gosd_pkg::value_t                    lft [gosd_pkg::MAX_GROUP+1];
  gosd_pkg::value_t                    rgt [gosd_pkg::MAX_GROUP+1];
  logic [gosd_pkg::MAX_GROUP:0]        vld;

  assign lft[0] = bcast.left;
  assign rgt[0] = bcast.right;
  assign vld[0] = 1'b1;

  for (genvar i = 0; i < gosd_pkg::MAX_GROUP; i++) begin : g_cell
    gosd_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .bcast      (bcast),
      .prev_left  (lft[i]),
      .prev_right (rgt[i]),
      .prev_valid (vld[i]),
      .cell_left  (lft[i+1]),
      .cell_right (rgt[i+1]),
      .cell_valid (vld[i+1]),
      .hit        (hits[i])
    );
  end

  assign full = vld[gosd_pkg::MAX_GROUP];

endmodule

// ===== hw/rtl/group_order_swap_detector.sv =====
// Group order swap detector: finds order-dependency swaps inside groups of a partition.
// Takes one tuple request per cycle while not stalled; each is compared at once with every stored
// tuple of its group in a row of 64 cells, and the registered hits are merged in the merge stage.
// The partition result is registered as its partition-end tuple leaves the merge stage. Input stalls
// only while a result waits unread and another partition-end tuple sits in the merge stage.
// Depends on gosd_pkg and gosd_cell_row.
module group_order_swap_detector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,      // ascending_order
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,      // left_value[31:0], right_value[63:32]
  input  logic        in_tuser,      // group_last
  input  logic        in_tlast,      // partition_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata      // swap_found[0], group_overflow[1], zero[7:2]
);

  localparam int VW = gosd_pkg::VALUE_WIDTH;

  logic                          asc_r;
  logic                          in_fire;
  logic                          full;
  logic [gosd_pkg::MAX_GROUP-1:0] hits;
  gosd_pkg::bcast_t              bcast;

  logic s1_vld_r;
  logic s1_vld_nxt;
  logic s1_plast_r;
  logic s1_ovf_r;
  logic s1_go;
  logic swap_seen_r;
  logic swap_seen_nxt;
  logic ovf_seen_r;
  logic ovf_seen_nxt;
  logic out_vld_r;
  logic out_vld_nxt;
  logic [1:0] out_flags_r;
  logic any_swap;
  logic any_ovf;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asc_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      asc_r <= cfg_data;
    end
  end

  assign s1_go     = s1_vld_r && !(s1_plast_r && out_vld_r && !out_tready);
  assign in_tready = !(s1_vld_r && !s1_go);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    bcast.load  = in_fire;
    bcast.shift = in_fire && !full;
    bcast.clear = in_fire && (in_tuser || in_tlast);
    bcast.asc   = asc_r;
    bcast.left  = in_tdata[VW-1:0];
    bcast.right = in_tdata[2*VW-1:VW];
  end

  gosd_cell_row u_row (
    .clk   (clk),
    .rst_n (rst_n),
    .bcast (bcast),
    .hits  (hits),
    .full  (full)
  );

  always_comb begin
    any_swap      = swap_seen_r || (|hits);
    any_ovf       = ovf_seen_r || s1_ovf_r;
    swap_seen_nxt = swap_seen_r;
    ovf_seen_nxt  = ovf_seen_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    s1_vld_nxt    = in_fire || (s1_vld_r && !s1_go);
    if (s1_go) begin
      if (s1_plast_r) begin
        swap_seen_nxt = 1'b0;
        ovf_seen_nxt  = 1'b0;
        out_vld_nxt   = 1'b1;
      end else begin
        swap_seen_nxt = any_swap;
        ovf_seen_nxt  = any_ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      swap_seen_r <= 1'b0;
      ovf_seen_r  <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      s1_vld_r    <= s1_vld_nxt;
      swap_seen_r <= swap_seen_nxt;
      ovf_seen_r  <= ovf_seen_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_plast_r <= in_tlast;
      s1_ovf_r   <= full;
    end
    if (s1_go && s1_plast_r) begin
      out_flags_r <= {any_ovf, any_swap};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, out_flags_r};

endmodule

// ===== hw/rtl/gosd_checker.sv =====
// Port-level checker for the group order swap detector, bound to the top level.
// Depends only on the top-level ports.
module gosd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       cfg_ready,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result request dropped or changed while stalled");

  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))
    else $error("result without a partition-end tuple");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a waiting result");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:2] == 6'b0)
    else $error("result padding not zero");

endmodule

bind group_order_swap_detector gosd_checker u_gosd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_ready  (cfg_ready),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
